### sv/pli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pli_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int DATA_W         = 32;
    localparam int IDX_W          = 6;
    localparam int CNT_W          = 7;
    localparam int REGION_W       = 2;
    localparam int Q_DEPTH        = 2;
    localparam int DIV_STEPS      = 2 * DATA_W;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [REGION_W-1:0] REGION_INSIDE = 2'd0;
    localparam logic [REGION_W-1:0] REGION_LOW    = 2'd1;
    localparam logic [REGION_W-1:0] REGION_HIGH   = 2'd2;
    localparam logic [REGION_W-1:0] REGION_EMPTY  = 2'd3;

    // One classified command: a load carries (x, y) in a/b, a query its x in a.
    typedef struct packed {
        logic              op;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

endpackage

`default_nettype wire

### sv/pli_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pli_front #(
    parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_func,
    input  wire logic [pli_pkg::IDX_W-1:0]   i_point_index,
    input  wire logic [pli_pkg::DATA_W-1:0]  i_point_x,
    input  wire logic [pli_pkg::DATA_W-1:0]  i_point_y,
    input  wire logic [pli_pkg::DATA_W-1:0]  i_query_x,
    output pli_pkg::t_head                   o_head,
    input  wire logic                        i_pop
);
    import pli_pkg::*;

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_cmd          r_q [Q_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;

    t_cmd cmd;
    logic keep;
    logic full;
    logic push;
    logic pop;

    // Classify: pack the fields that the op needs, drop loads beyond the table.
    always_comb begin
        cmd.op  = i_func;
        cmd.idx = i_point_index;
        if (i_func == FUNC_LOAD) begin
            cmd.a = i_point_x;
            cmd.b = i_point_y;
            keep  = (32'(i_point_index) < 32'(MAX_POINTS));
        end else begin
            cmd.a = i_query_x;
            cmd.b = '0;
            keep  = 1'b1;
        end
    end

    assign full       = (r_count == CW'(Q_DEPTH));
    assign o_in_stall = full;
    assign push       = i_in_valid && !full && keep;
    assign pop        = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd;
        end
    end

endmodule

`default_nettype wire

### sv/pli_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pli_back #(
    parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [pli_pkg::CNT_W-1:0]     i_num_points,
    input  wire pli_pkg::t_head                i_head,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [pli_pkg::DATA_W-1:0]         o_y_value,
    output logic [pli_pkg::REGION_W-1:0]       o_region
);
    import pli_pkg::*;

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int NW  = $clog2(MAX_POINTS + 1);
    localparam int CW  = (NW > CNT_W) ? NW : CNT_W;
    localparam int DCW = $clog2(DIV_STEPS);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LAST  = 7'b0000010,
        S_FIRST = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [DATA_W-1:0] mem_x [MAX_POINTS];
    logic [DATA_W-1:0] mem_y [MAX_POINTS];
    logic [DATA_W-1:0] r_rd_x, r_rd_y;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;

    logic [DATA_W-1:0]   r_qx,     n_qx;
    logic [DATA_W-1:0]   r_last_x, n_last_x;
    logic [DATA_W-1:0]   r_last_y, n_last_y;
    logic [DATA_W-1:0]   r_prev_x, n_prev_x;
    logic [DATA_W-1:0]   r_prev_y, n_prev_y;
    logic [AW-1:0]       r_idx,    n_idx;
    logic [AW-1:0]       r_nlast,  n_nlast;
    logic [DATA_W-1:0]   r_off,    n_off;
    logic [DATA_W-1:0]   r_mag,    n_mag;
    logic [DATA_W-1:0]   r_dx,     n_dx;
    logic                r_neg,    n_neg;
    logic [2*DATA_W-1:0] r_num,    n_num;
    logic [DATA_W-1:0]   r_rem,    n_rem;
    logic [DCW-1:0]      r_cnt,    n_cnt;
    logic [DATA_W-1:0]   r_res_y,  n_res_y;
    logic [REGION_W-1:0] r_res_rg, n_res_rg;
    logic                r_out_valid, n_out_valid;
    logic [DATA_W-1:0]   r_out_y;
    logic [REGION_W-1:0] r_out_rg;
    logic                out_load;

    logic [CW-1:0]       num_w, n_eff;
    logic [AW-1:0]       n_last;
    logic                empty;
    logic [DATA_W:0]     dx_w, dy_w, off_w;
    logic [2*DATA_W-1:0] prod;
    logic [DATA_W:0]     trial, diff;
    logic                ge;
    logic [DATA_W-1:0]   quot;

    // Effective count, clipped to the table depth.
    always_comb begin
        num_w  = CW'(i_num_points);
        n_eff  = (num_w > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : num_w;
        n_last = AW'(n_eff - CW'(1));
        empty  = (n_eff == '0);
    end

    // Segment arithmetic on the entry just read against the previous one.
    always_comb begin
        dx_w  = {r_rd_x[DATA_W-1], r_rd_x} - {r_prev_x[DATA_W-1], r_prev_x};
        dy_w  = {r_rd_y[DATA_W-1], r_rd_y} - {r_prev_y[DATA_W-1], r_prev_y};
        off_w = {r_qx[DATA_W-1], r_qx} - {r_prev_x[DATA_W-1], r_prev_x};
    end

    assign prod = r_off * r_mag;

    // One restoring division step: quotient bits shift into r_num.
    always_comb begin
        trial = {r_rem, r_num[2*DATA_W-1]};
        diff  = trial - {1'b0, r_dx};
        ge    = (trial >= {1'b0, r_dx});
        quot  = {r_num[DATA_W-2:0], ge};
    end

    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state  = r_state;
        n_qx     = r_qx;
        n_last_x = r_last_x;
        n_last_y = r_last_y;
        n_prev_x = r_prev_x;
        n_prev_y = r_prev_y;
        n_idx    = r_idx;
        n_nlast  = r_nlast;
        n_off    = r_off;
        n_mag    = r_mag;
        n_dx     = r_dx;
        n_neg    = r_neg;
        n_num    = r_num;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_res_y  = r_res_y;
        n_res_rg = r_res_rg;
        o_pop    = 1'b0;
        wr_en    = 1'b0;
        rd_addr  = r_idx;
        unique case (r_state)
            S_IDLE: begin
                rd_addr = n_last;
                n_nlast = n_last;
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    if (i_head.cmd.op == FUNC_LOAD) begin
                        wr_en = 1'b1;
                    end else begin
                        n_qx = i_head.cmd.a;
                        if (empty) begin
                            n_res_y  = '0;
                            n_res_rg = REGION_EMPTY;
                            n_state  = S_OUT;
                        end else begin
                            n_state = S_LAST;
                        end
                    end
                end
            end
            S_LAST: begin
                n_last_x = r_rd_x;
                n_last_y = r_rd_y;
                rd_addr  = '0;
                n_state  = S_FIRST;
            end
            S_FIRST: begin
                rd_addr = AW'(1);
                if ($signed(r_qx) <= $signed(r_rd_x)) begin
                    n_res_y  = r_rd_y;
                    n_res_rg = REGION_LOW;
                    n_state  = S_OUT;
                end else if ($signed(r_qx) >= $signed(r_last_x)) begin
                    n_res_y  = r_last_y;
                    n_res_rg = REGION_HIGH;
                    n_state  = S_OUT;
                end else begin
                    n_prev_x = r_rd_x;
                    n_prev_y = r_rd_y;
                    n_idx    = AW'(1);
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                rd_addr = r_idx + 1'b1;
                if ($signed(r_qx) >= $signed(r_prev_x) &&
                        $signed(r_qx) <= $signed(r_rd_x)) begin
                    if (dx_w[DATA_W] || dx_w == '0) begin
                        n_res_y  = r_prev_y;
                        n_res_rg = REGION_INSIDE;
                        n_state  = S_OUT;
                    end else begin
                        n_dx    = dx_w[DATA_W-1:0];
                        n_off   = off_w[DATA_W-1:0];
                        n_neg   = dy_w[DATA_W];
                        n_mag   = dy_w[DATA_W] ? DATA_W'(-dy_w) : dy_w[DATA_W-1:0];
                        n_state = S_MUL;
                    end
                end else if (r_idx == r_nlast) begin
                    n_res_y  = r_last_y;
                    n_res_rg = REGION_HIGH;
                    n_state  = S_OUT;
                end else begin
                    n_prev_x = r_rd_x;
                    n_prev_y = r_rd_y;
                    n_idx    = r_idx + 1'b1;
                end
            end
            S_MUL: begin
                n_num   = prod;
                n_rem   = '0;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
                n_num = {r_num[2*DATA_W-2:0], ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DCW'(DIV_STEPS - 1)) begin
                    n_res_y  = r_neg ? r_prev_y - quot : r_prev_y + quot;
                    n_res_rg = REGION_INSIDE;
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_qx     <= n_qx;
        r_last_x <= n_last_x;
        r_last_y <= n_last_y;
        r_prev_x <= n_prev_x;
        r_prev_y <= n_prev_y;
        r_idx    <= n_idx;
        r_nlast  <= n_nlast;
        r_off    <= n_off;
        r_mag    <= n_mag;
        r_dx     <= n_dx;
        r_neg    <= n_neg;
        r_num    <= n_num;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_res_y  <= n_res_y;
        r_res_rg <= n_res_rg;
        if (out_load) begin
            r_out_y  <= r_res_y;
            r_out_rg <= r_res_rg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_x[AW'(i_head.cmd.idx)] <= i_head.cmd.a;
            mem_y[AW'(i_head.cmd.idx)] <= i_head.cmd.b;
        end
        r_rd_x <= mem_x[rd_addr];
        r_rd_y <= mem_y[rd_addr];
    end

    assign o_out_valid = r_out_valid;
    assign o_y_value   = r_out_y;
    assign o_region    = r_out_rg;

endmodule

`default_nettype wire

### sv/piecewise_linear_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none
// Flow: a load goes through the front queue and the idle back end writes it to the table;
//   a query result enters the output register directly on an empty table, after reading
//   the last and first entries when clamped, else after one table read per scanned segment,
//   a multiply and 64 divide steps if dx > 0; add any wait for a busy back end or a stalled output.
// Throughput: one query at a time in the back end; loads retire one per cycle while idle.
// Reset (i_rst_n low, synchronous): count to 0, queue and output empty; table kept.

module piecewise_linear_interpolator #(
    parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input items
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_func,
    input  wire logic [pli_pkg::IDX_W-1:0]     i_point_index,
    input  wire logic [pli_pkg::DATA_W-1:0]    i_point_x,
    input  wire logic [pli_pkg::DATA_W-1:0]    i_point_y,
    input  wire logic [pli_pkg::DATA_W-1:0]    i_query_x,
    // results
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [pli_pkg::DATA_W-1:0]         o_y_value,
    output logic [pli_pkg::REGION_W-1:0]       o_region,
    // num_points register
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [pli_pkg::CNT_W-1:0]     i_cfg_data
);
    import pli_pkg::*;

    logic [CNT_W-1:0] r_num_points;
    t_head            head;
    logic             pop;

    // Accept every write, unchecked; the sender must change the count only while the block is idle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_num_points <= i_cfg_data;
        end
    end

    // Front end: take transactions, drop out-of-range loads, hold them in a short queue.
    pli_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_point_index (i_point_index),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_query_x     (i_query_x),
        .o_head        (head),
        .i_pop         (pop)
    );

    // Back end: write the table on loads; on queries answer an empty table or clamp, scan
    // for the enclosing segment, multiply, divide serially; hold results in an output register.
    pli_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_num_points (r_num_points),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_y_value    (o_y_value),
        .o_region     (o_region)
    );

endmodule

`default_nettype wire

### tb/tb_piecewise_linear_interpolator.sv
`timescale 1ns / 1ps

module tb_piecewise_linear_interpolator;
    import pli_pkg::*;

    localparam int     MAX_PTS     = MAX_POINTS_DEF;
    localparam int     ITEM_BUDGET = 1550;
    // Loads pass through the front queue, which holds two entries, before the back
    // end writes them into the table, so a short settle covers them.
    localparam int     SETTLE_CYC  = 10;
    // Give the tail some margin past the slowest query.
    localparam int     TAIL_CYC    = 150;
    // Allow well over the slowest legal run before giving up.
    localparam longint TIMEOUT_NS  = 30_000_000;
    localparam longint X_MAX       = 64'sd2147483647;
    localparam longint X_MIN       = -64'sd2147483648;

    typedef longint unsigned u64_t;

    // One interpolated answer, as it leaves the block.
    typedef struct packed {
        logic [DATA_W-1:0]   y_value;
        logic [REGION_W-1:0] region;
    } interp_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_QUERY} row_kind_e;

    // Directed stimulus row: a load uses (a, b) as (x, y), a query uses a as
    // its x, a count write uses the low bits of a. When typed is set the
    // answer is written into the row instead of being predicted.
    typedef struct {
        row_kind_e         kind;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        bit                typed;
        interp_t           want;
    } dir_row_t;

    localparam int NUM_DIR = 24;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic                i_func        = FUNC_LOAD;
    logic [IDX_W-1:0]    i_point_index = '0;
    logic [DATA_W-1:0]   i_point_x     = '0;
    logic [DATA_W-1:0]   i_point_y     = '0;
    logic [DATA_W-1:0]   i_query_x     = '0;
    logic                i_out_stall   = 1'b0;
    logic                i_cfg_valid   = 1'b0;
    logic [CNT_W-1:0]    i_cfg_data    = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [DATA_W-1:0]   o_y_value;
    logic [REGION_W-1:0] o_region;
    logic                o_cfg_ready;

    // Shadow of the breakpoint table and the point count.
    logic signed [DATA_W-1:0] bp_x [MAX_PTS];
    logic signed [DATA_W-1:0] bp_y [MAX_PTS];
    logic [CNT_W-1:0]         count_reg = '0;

    // Answers owed by the block, oldest first.
    interp_t     predicted_results [$];
    dir_row_t    directed_rows [NUM_DIR];
    int unsigned items_issued  = 0;
    int unsigned burst_left    = 0;
    int unsigned mismatches    = 0;
    int unsigned out_hold_left = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    piecewise_linear_interpolator #(
        .MAX_POINTS(MAX_PTS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_point_index(i_point_index),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_query_x    (i_query_x),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_y_value    (o_y_value),
        .o_region     (o_region),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    // Interpolate at qx over the shadow table: empty on no points, clamp at or
    // beyond the first and last breakpoint, otherwise walk the segments and take
    // the first one that encloses qx, with a truncating divide on the exact product.
    function automatic interp_t predict_interp(input logic signed [DATA_W-1:0] qx);
        int     n;
        int     i;
        longint x0, x1, y0, y1, dx, dy;
        u64_t   span, mag, quo;
        n = (count_reg > MAX_PTS) ? MAX_PTS : int'(count_reg);
        if (n == 0)
            return {{DATA_W{1'b0}}, REGION_EMPTY};
        if (qx <= bp_x[0])
            return {bp_y[0], REGION_LOW};
        if (qx >= bp_x[n-1])
            return {bp_y[n-1], REGION_HIGH};
        for (i = 0; i + 1 < n; i++) begin
            x0 = bp_x[i];
            x1 = bp_x[i+1];
            if (qx >= x0 && qx <= x1) begin
                y0 = bp_y[i];
                y1 = bp_y[i+1];
                dx = x1 - x0;
                dy = y1 - y0;
                // A segment with no positive width yields its left y.
                if (dx <= 0)
                    return {y0[DATA_W-1:0], REGION_INSIDE};
                // (qx - x0) <= dx < 2^32 and |dy| < 2^32: the product fits 64 bits.
                mag  = (dy < 0) ? u64_t'(-dy) : u64_t'(dy);
                span = u64_t'(longint'(qx) - x0);
                quo  = (span * mag) / u64_t'(dx);
                y0   = (dy < 0) ? y0 - longint'(quo) : y0 + longint'(quo);
                return {y0[DATA_W-1:0], REGION_INSIDE};
            end
        end
        // Table not ascending and no segment encloses qx.
        return {bp_y[n-1], REGION_HIGH};
    endfunction

    function automatic dir_row_t mk_row(input row_kind_e kind, input logic [IDX_W-1:0] idx,
                                        input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
                                        input bit typed, input logic [DATA_W-1:0] y,
                                        input logic [REGION_W-1:0] region);
        dir_row_t r;
        r.kind  = kind;
        r.idx   = idx;
        r.a     = a;
        r.b     = b;
        r.typed = typed;
        r.want  = {y, region};
        return r;
    endfunction

    // Pick a query x aimed at the loaded table: mostly anywhere from its first
    // to its last x, sometimes on a breakpoint, just past either end, or anywhere at all.
    function automatic logic [DATA_W-1:0] pick_query_x(input int unsigned n);
        longint lo, hi, v;
        if (n == 0)
            return $urandom;
        lo = bp_x[0];
        hi = bp_x[n-1];
        case ($urandom_range(0, 15))
            0:       return $urandom;
            1:       v = lo;
            2:       v = hi;
            3:       v = lo - 1;
            4:       v = hi + 1;
            5:       v = bp_x[$urandom_range(0, n - 1)];
            default: v = (hi > lo) ? lo + longint'(u64_t'($urandom) % u64_t'(hi - lo + 1)) : lo;
        endcase
        if (v > X_MAX)
            v = X_MAX;
        if (v < X_MIN)
            v = X_MIN;
        return v[DATA_W-1:0];
    endfunction

    // Present one transaction and hold it until accepted. The sender runs in
    // bursts: when a burst is used up, drop valid for a random gap first.
    task automatic send_item(input logic func, input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] px, input logic [DATA_W-1:0] py,
                             input logic [DATA_W-1:0] qx, input bit typed,
                             input interp_t typed_res);
        int unsigned gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_func        <= func;
        i_point_index <= idx;
        i_point_x     <= px;
        i_point_y     <= py;
        i_query_x     <= qx;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        items_issued++;
        // Advance the shadow state in transaction order.
        if (func == FUNC_LOAD) begin
            if (idx < MAX_PTS) begin
                bp_x[idx] = px;
                bp_y[idx] = py;
            end
        end else begin
            predicted_results.insert(predicted_results.size(),
                                     typed ? typed_res : predict_interp(qx));
        end
    endtask

    // Drop valid and hold off until every owed answer is back and the last
    // loads have had time to reach the table.
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic set_point_count(input logic [CNT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        count_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Result side back-pressure: short stalls, free-running stretches and the
    // occasional long quiet stretch, independent of the sender.
    always @(negedge i_clk) begin
        int unsigned pick;
        if (out_hold_left != 0) begin
            out_hold_left <= out_hold_left - 1;
        end else begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                i_out_stall   <= 1'b0;
                out_hold_left <= 80;
            end else if (pick < 4) begin
                i_out_stall   <= 1'b1;
                out_hold_left <= $urandom_range(0, 7);
            end else begin
                i_out_stall   <= 1'b0;
                out_hold_left <= $urandom_range(0, 19);
            end
        end
    end

    // Compare every accepted result against the oldest owed answer.
    always @(posedge i_clk) begin
        interp_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (predicted_results.size() == 0) begin
                $error("result with nothing outstanding: y_value %h region %0d",
                       o_y_value, o_region);
                mismatches = mismatches + 1;
            end else begin
                want = predicted_results.pop_front();
                if (o_y_value !== want.y_value) begin
                    $error("y_value: expected %h, actual %h", want.y_value, o_y_value);
                    mismatches = mismatches + 1;
                end
                if (o_region !== want.region) begin
                    $error("region: expected %0d, actual %0d", want.region, o_region);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $error("run did not complete in time, %0d answers still owed",
               predicted_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int unsigned      opening_counts [4];
        int unsigned      phase, cnt_val, neff, scale, n_items, k, sel;
        int               ya;
        longint           xa;
        logic [IDX_W-1:0] slot;

        opening_counts = '{127, 64, 0, 1};

        //                kind       idx    a              b             typed y              region
        directed_rows = '{
            mk_row(ROW_QUERY, '0,    32'h0000_0000, '0,           1'b1, 32'h0000_0000, REGION_EMPTY),
            mk_row(ROW_QUERY, '0,    32'hFFFF_FFFF, '0,           1'b1, 32'h0000_0000, REGION_EMPTY),
            mk_row(ROW_LOAD,  6'd0,  32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0,           REGION_INSIDE),
            mk_row(ROW_CFG,   '0,    32'd1,         '0,           1'b0, '0,            REGION_INSIDE),
            mk_row(ROW_QUERY, '0,    32'h8000_0000, '0,           1'b1, 32'h7FFF_FFFF, REGION_LOW),
            mk_row(ROW_QUERY, '0,    32'h7FFF_FFFF, '0,           1'b1, 32'h7FFF_FFFF, REGION_HIGH),
            mk_row(ROW_LOAD,  6'd1,  32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0,           REGION_INSIDE),
            mk_row(ROW_CFG,   '0,    32'd2,         '0,           1'b0, '0,            REGION_INSIDE),
            mk_row(ROW_QUERY, '0,    32'h0000_0000, '0,           1'b0, '0,            REGION_INSIDE),
            mk_row(ROW_QUERY, '0,    32'h7FFF_FFFE, '0,           1'b0, '0,            REGION_INSIDE),
            mk_row(ROW_QUERY, '0,    32'h7FFF_FFFF, '0,           1'b1, 32'h8000_0000, REGION_HIGH),
            mk_row(ROW_LOAD,  6'd63, 32'h1234_5678, 32'hFFFF_FFFF, 1'b0, '0,           REGION_INSIDE),
            mk_row(ROW_LOAD,  6'd1,  32'h0001_0000, 32'h0003_0000, 1'b0, '0,           REGION_INSIDE),
            mk_row(ROW_LOAD,  6'd2,  32'h0001_0000, 32'hFFFF_0000, 1'b0, '0,           REGION_INSIDE),
            mk_row(ROW_LOAD,  6'd3,  32'h0004_0000, 32'h0002_0000, 1'b0, '0,           REGION_INSIDE),
            mk_row(ROW_CFG,   '0,    32'd4,         '0,           1'b0, '0,            REGION_INSIDE),
            mk_row(ROW_QUERY, '0,    32'h0001_0000, '0,           1'b0, '0,            REGION_INSIDE),
            mk_row(ROW_QUERY, '0,    32'h0001_8000, '0,           1'b0, '0,            REGION_INSIDE),
            mk_row(ROW_QUERY, '0,    32'h0000_8000, '0,           1'b0, '0,            REGION_INSIDE),
            mk_row(ROW_LOAD,  6'd2,  32'hFFFF_0000, 32'h0005_0000, 1'b0, '0,           REGION_INSIDE),
            mk_row(ROW_QUERY, '0,    32'h0002_0000, '0,           1'b0, '0,            REGION_INSIDE),
            mk_row(ROW_QUERY, '0,    32'h0004_0000, '0,           1'b1, 32'h0002_0000, REGION_HIGH),
            mk_row(ROW_CFG,   '0,    32'd0,         '0,           1'b0, '0,            REGION_INSIDE),
            mk_row(ROW_QUERY, '0,    32'h0002_0000, '0,           1'b1, 32'h0000_0000, REGION_EMPTY)
        };

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty table, single point, full-scale segment,
        // duplicate breakpoints, a table put out of order, back to empty.
        foreach (directed_rows[r]) begin
            case (directed_rows[r].kind)
                ROW_CFG: begin
                    wait_idle();
                    set_point_count(directed_rows[r].a[CNT_W-1:0]);
                end
                ROW_LOAD: begin
                    send_item(FUNC_LOAD, directed_rows[r].idx, directed_rows[r].a,
                              directed_rows[r].b, $urandom, 1'b0, '0);
                end
                default: begin
                    send_item(FUNC_QUERY, IDX_W'($urandom), $urandom, $urandom,
                              directed_rows[r].a, directed_rows[r].typed,
                              directed_rows[r].want);
                end
            endcase
        end

        // Random part, in phases. Each phase sets a count while idle, loads
        // an ascending table over every slot in use, then mostly queries it
        // with a little load noise on top.
        phase = 0;
        while (items_issued < ITEM_BUDGET) begin
            if (phase < 4) begin
                cnt_val = opening_counts[phase];
            end else begin
                sel = $urandom_range(0, 19);
                if (sel == 0)
                    cnt_val = 0;
                else if (sel == 1)
                    cnt_val = 1;
                else if (sel == 2)
                    cnt_val = 2;
                else if (sel == 3)
                    cnt_val = 64;
                else if (sel == 4)
                    cnt_val = $urandom_range(65, 127);   // over the table size
                else
                    cnt_val = $urandom_range(3, 10);
            end
            phase++;
            wait_idle();
            set_point_count(CNT_W'(cnt_val));
            neff = (cnt_val > MAX_PTS) ? MAX_PTS : cnt_val;

            // Build the table: random start, random steps at a random scale,
            // now and then a repeated x. Keep the steps small enough that a
            // full table stays inside the signed range; clamp just in case.
            scale = $urandom_range(2, (neff > 8) ? 23 : 27);
            xa    = ($urandom_range(0, 7) == 0) ? X_MIN : (longint'(int'($urandom)) >>> 1);
            for (k = 0; k < neff; k++) begin
                if (k != 0 && $urandom_range(0, 15) != 0)
                    xa += $urandom_range(1, 1 << scale);
                if (xa > X_MAX)
                    xa = X_MAX;
                ya = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 2097152)) - 1048576
                                                 : int'($urandom);
                send_item(FUNC_LOAD, IDX_W'(k), DATA_W'(xa), DATA_W'(ya), $urandom, 1'b0, '0);
            end

            n_items = $urandom_range(20, 60);
            for (k = 0; k < n_items; k++) begin
                sel = $urandom_range(0, 99);
                // Now and then hold the sender until every answer is back.
                if (sel < 2)
                    wait_idle();
                if (sel < 8 || (sel < 14 && neff == 0)) begin
                    // Noise: any slot, any point; may break the ordering.
                    send_item(FUNC_LOAD, IDX_W'($urandom), $urandom, $urandom, $urandom,
                              1'b0, '0);
                end else if (sel < 14) begin
                    // Move a breakpoint's y, keep its x.
                    slot = IDX_W'($urandom_range(0, neff - 1));
                    send_item(FUNC_LOAD, slot, bp_x[slot], $urandom, $urandom, 1'b0, '0);
                end else begin
                    send_item(FUNC_QUERY, IDX_W'($urandom), $urandom, $urandom,
                              pick_query_x(neff), 1'b0, '0);
                end
            end
        end

        // Drain, then watch a while longer for anything unexpected.
        wait_idle();
        repeat (TAIL_CYC) @(posedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
